FILE: sv/depth_histogram_equalizer_assert.svh
// Assertion macros shared by the depth histogram equalizer RTL.
`ifndef DEPTH_HISTOGRAM_EQUALIZER_ASSERT_SVH
`define DEPTH_HISTOGRAM_EQUALIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// General property, sampled on the rising clock, off while reset is low
`define DHE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, off while reset is low
`define DHE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define DHE_ASSERT(lbl, clk, rst_n, prop, msg)

`define DHE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/dhe_pkg.sv
// Types and constants of the depth histogram equalizer.
package dhe_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned GRAY_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Quotient steps of the shared divider (gray levels are 8 bits)
  localparam int unsigned QUOT_W   = GRAY_W;
  localparam int unsigned STEP_W   = $clog2(QUOT_W);

  // 255 * diff is formed as (diff << 8) - diff
  localparam int unsigned LIN_W    = THR_W + GRAY_W;

  localparam logic [THR_W-1:0] THR_RESET = 15'd16384;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_COUNT  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_MAP    = 2'd3
  } dhe_cmd_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_THRESHOLD  = 2'd0,
    REG_HISTOGRAM_ENABLE = 2'd1
  } dhe_reg_e;

endpackage

FILE: sv/depth_histogram_equalizer.sv
// Top level: sequencer, histogram store and shared divider of the equalizer.
//
// Channel  Dir  Handshake                   Payload
// in       in   in_valid_i / in_ready_o     command_i, depth_i
// out      out  out_valid_o / out_ready_i   gray_o
// cfg      in   cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// Per beat: a count reads and rewrites one bin (not when the pixel is dropped), a
// table map reads one bin, a linear map divides once, an invalid map loads 0, finish
// divides per bin 1 to DEPTH_LEVELS - 1 (not with no points), clear writes all bins.
// After reset a clearing pass over all bins runs before in_ready_o rises.
// A gray level waits in the output register; the next map holds until it is taken.
// Configuration beats are taken in every cycle.
`include "depth_histogram_equalizer_assert.svh"

module depth_histogram_equalizer
  import dhe_pkg::*;
#(
  parameter int unsigned DEPTH_LEVELS = 16384,
  parameter int unsigned COUNT_BITS   = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [DEPTH_W-1:0]   depth_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [GRAY_W-1:0]    gray_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [THR_W-1:0]     cfg_data_i
);

  localparam int unsigned AW    = $clog2(DEPTH_LEVELS);
  localparam int unsigned DIV_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam logic [AW-1:0]         LAST_IDX   = AW'(DEPTH_LEVELS - 1);
  localparam logic [DEPTH_W:0]      LEVELS_CMP = (DEPTH_W + 1)'(DEPTH_LEVELS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  // Sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_CLEAR     = 4'd1;
  localparam logic [3:0] ST_CNT_RD    = 4'd2;
  localparam logic [3:0] ST_CNT_WR    = 4'd3;
  localparam logic [3:0] ST_MAP_RD    = 4'd4;
  localparam logic [3:0] ST_MAP_GET   = 4'd5;
  localparam logic [3:0] ST_LIN_SUB   = 4'd6;
  localparam logic [3:0] ST_LIN_START = 4'd7;
  localparam logic [3:0] ST_LIN_WAIT  = 4'd8;
  localparam logic [3:0] ST_OUT       = 4'd9;
  localparam logic [3:0] ST_FIN_RD    = 4'd10;
  localparam logic [3:0] ST_FIN_ACC   = 4'd11;
  localparam logic [3:0] ST_FIN_START = 4'd12;
  localparam logic [3:0] ST_FIN_WAIT  = 4'd13;
  localparam logic [3:0] ST_FIN_WR    = 4'd14;

  logic [3:0]            state_q, state_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] cum_q, cum_d;
  logic [THR_W-1:0]      thr_q, thr_d;
  logic                  hist_q, hist_d;
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic [THR_W-1:0]      lin_diff_q, lin_diff_d;
  logic [GRAY_W-1:0]     result_q, result_d;
  logic                  out_valid_q, out_valid_d;
  logic [GRAY_W-1:0]     gray_q;
  logic                  out_load;

  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_addr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic                  div_start;
  logic [DIV_W-1:0]      div_rem;
  logic [QUOT_W-1:0]     div_low;
  logic [DIV_W-1:0]      div_divisor;
  logic                  div_busy;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;

  logic                  pix_ok;
  logic [COUNT_BITS:0]   cum_sum;
  logic [LIN_W-1:0]      lin_prod;
  logic [AW-1:0]         pix_addr;

  // Pixel check on the incoming beat
  assign pix_ok = (depth_i != '0)
               && ({1'b0, depth_i} < {{(DEPTH_W + 1 - THR_W){1'b0}}, thr_q})
               && ({1'b0, depth_i} < LEVELS_CMP);

  assign cum_sum  = {1'b0, cum_q} + {1'b0, ram_rdata};
  assign lin_prod = {lin_diff_q, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, lin_diff_q};
  assign pix_addr = depth_q[AW-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    cum_d       = cum_q;
    thr_d       = thr_q;
    hist_d      = hist_q;
    depth_d     = depth_q;
    lin_diff_d  = lin_diff_q;
    result_d    = result_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = pix_addr;
    ram_wdata   = '0;
    div_start   = 1'b0;
    div_rem     = DIV_W'(count_q - cum_q);
    div_low     = '0;
    div_divisor = DIV_W'(count_q);

    // Register writes
    if (cfg_valid_i) begin
      case (dhe_reg_e'(cfg_index_i))
        REG_DEPTH_THRESHOLD:  thr_d  = cfg_data_i;
        REG_HISTOGRAM_ENABLE: hist_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          depth_d = depth_i;
          case (dhe_cmd_e'(command_i))
            CMD_CLEAR: begin
              idx_d   = '0;
              count_d = '0;
              state_d = ST_CLEAR;
            end
            CMD_COUNT: begin
              // A full count drops the pixel altogether
              if (pix_ok && (count_q != COUNT_MAX)) begin
                count_d = count_q + 1'b1;
                state_d = ST_CNT_RD;
              end
            end
            CMD_FINISH: begin
              // Bin 0 never counts, so the walk starts at bin 1 with sum 0
              if (count_q != '0) begin
                idx_d   = AW'(1);
                cum_d   = '0;
                state_d = ST_FIN_RD;
              end
            end
            CMD_MAP: begin
              if (!pix_ok) begin
                result_d = '0;
                state_d  = ST_OUT;
              end else if (hist_q) begin
                state_d  = ST_MAP_RD;
              end else begin
                state_d  = ST_LIN_SUB;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = idx_q;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_CNT_RD: begin
        ram_re  = 1'b1;
        state_d = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata + COUNT_BITS'(1);
        state_d   = ST_IDLE;
      end
      ST_MAP_RD: begin
        ram_re  = 1'b1;
        state_d = ST_MAP_GET;
      end
      ST_MAP_GET: begin
        result_d = ram_rdata[GRAY_W-1:0];
        state_d  = ST_OUT;
      end
      ST_LIN_SUB: begin
        lin_diff_d = thr_q - depth_q[THR_W-1:0];
        state_d    = ST_LIN_START;
      end
      ST_LIN_START: begin
        // 255 * (thr - d) / thr
        div_start   = 1'b1;
        div_rem     = DIV_W'(lin_prod[LIN_W-1:GRAY_W]);
        div_low     = lin_prod[GRAY_W-1:0];
        div_divisor = DIV_W'(thr_q);
        state_d     = ST_LIN_WAIT;
      end
      ST_LIN_WAIT: begin
        if (div_done) begin
          result_d = div_quot;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_FIN_RD: begin
        ram_re   = 1'b1;
        ram_addr = idx_q;
        state_d  = ST_FIN_ACC;
      end
      ST_FIN_ACC: begin
        // Clamp the running sum at N: the rest is zero from there on
        cum_d   = (cum_sum > {1'b0, count_q}) ? count_q : cum_sum[COUNT_BITS-1:0];
        state_d = ST_FIN_START;
      end
      ST_FIN_START: begin
        // 256 * (N - cum) / N, all ones when cum is zero
        div_start = 1'b1;
        state_d   = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        if (div_done) begin
          state_d = ST_FIN_WR;
        end
      end
      ST_FIN_WR: begin
        ram_we    = 1'b1;
        ram_addr  = idx_q;
        ram_wdata = COUNT_BITS'(div_quot);
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_FIN_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || out_load;

  // Control and register state; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      count_q     <= '0;
      thr_q       <= THR_RESET;
      hist_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      thr_q       <= thr_d;
      hist_q      <= hist_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cum_q      <= cum_d;
    depth_q    <= depth_d;
    lin_diff_q <= lin_diff_d;
    result_q   <= result_d;
    if (out_load) begin
      gray_q <= result_q;
    end
  end

  dhe_bin_ram #(
    .DEPTH (DEPTH_LEVELS),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  dhe_divider #(
    .DIV_W (DIV_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_i     (div_rem),
    .low_i     (div_low),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign gray_o      = gray_q;

  `DHE_ASSERT_IMPLIES(a_ready_div_idle, clk_i, rst_ni, in_ready_o, !div_busy,
                      "ready while the divider works")
  `DHE_ASSERT_IMPLIES(a_bin0_kept, clk_i, rst_ni, state_q == ST_FIN_WR, idx_q != '0,
                      "finish wrote bin 0")
  `DHE_ASSERT_IMPLIES(a_count_drop_clear, clk_i, rst_ni, count_q < $past(count_q),
                      $past(state_q == ST_IDLE) && $past(in_valid_i)
                      && ($past(command_i) == CMD_CLEAR),
                      "point count fell without a clear")

endmodule

FILE: sv/dhe_bin_ram.sv
// Single-port bin store with registered read data.
module dhe_bin_ram
  import dhe_pkg::*;
#(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14,
  parameter int unsigned DW    = 20
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // One access a cycle; read data held until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/dhe_divider.sv
// Shared restoring divider: one quotient bit a cycle, 8-bit quotient.
`include "depth_histogram_equalizer_assert.svh"

module dhe_divider
  import dhe_pkg::*;
#(
  parameter int unsigned DIV_W = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  rem_i,      // dividend >> 8, at most the divisor
  input  logic [QUOT_W-1:0] low_i,      // low 8 bits of the dividend
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]  rem_q;
  logic [QUOT_W-1:0] low_q;
  logic [DIV_W-1:0]  div_q;
  logic [QUOT_W-1:0] quot_q;

  logic [DIV_W:0]    trial;
  logic              fits;
  logic [DIV_W:0]    diff;

  // One step: shift in the next dividend bit, subtract when it fits.
  // A remainder equal to the divisor yields all ones, which is the saturation.
  assign trial = {rem_q, low_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      low_q  <= low_i;
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_q  <= {low_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  `DHE_ASSERT_IMPLIES(a_start_idle, clk_i, rst_ni, start_i, !busy_q, "divider started while busy")
  `DHE_ASSERT(a_last_step_done, clk_i, rst_ni, busy_q && !start_i && (cnt_q == LAST_STEP) |=> done_q && !busy_q, "divider missed its done beat")
  `DHE_ASSERT_IMPLIES(a_done_after_busy, clk_i, rst_ni, done_q, $past(busy_q), "done without a division")

endmodule
